/* rtl/irpfd_pkg.sv */
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared types and constants for the infrared printer frame decoder: frame
// geometry, byte codes, parity masks and result codes.
// ----------------------------------------------------------------------------
package irpfd_pkg;

  // Frame geometry
  localparam int unsigned FrameHalfBits = 30;
  localparam int unsigned CountW        = 5;
  localparam int unsigned ShiftW        = FrameHalfBits - 1;

  // Special byte values
  localparam logic [7:0] ByteEot    = 8'd4;
  localparam logic [7:0] ByteDrawOn = 8'd27;

  // Blocks per image after reset
  localparam logic [3:0] BlocksPerImageRst = 4'd4;

  // Parity masks, first entry gives check bit 3
  localparam logic [7:0] CheckMask [4] = '{8'h78, 8'hE6, 8'hD5, 8'h8B};

  // Frame status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_START = 2'd1,
    STAT_BAD_PAIR  = 2'd2
  } status_t;

  // Byte classification codes
  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_EOT     = 3'd1,
    KIND_DRAW_ON = 3'd2,
    KIND_COL_CNT = 3'd3,
    KIND_COLUMN  = 3'd4,
    KIND_NONE    = 3'd5
  } kind_t;

  // Completed frame handed from collector to decoder
  typedef struct packed {
    logic                     vld;
    logic [FrameHalfBits-1:0] bits;
  } frame_t;

endpackage

/* rtl/irpfd_collect.sv */
// ----------------------------------------------------------------------------
// irpfd_collect
// Half-bit collector: waits for a pulse, gathers 30 half-bits and holds the
// completed frame until the decoder takes it.
// ----------------------------------------------------------------------------
module irpfd_collect (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_pulse_seen,
  input  logic              dec_ready,
  output irpfd_pkg::frame_t frame
);
  import irpfd_pkg::*;

  logic              collecting_r, collecting_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [ShiftW-1:0] shift_r, shift_nxt;
  frame_t            frame_r, frame_nxt;
  logic              xfer;
  logic              last;

  // Input transfer; stall only while a finished frame waits on the decoder
  assign in_stall = frame_r.vld && !dec_ready;
  assign xfer     = in_valid && !in_stall;
  assign last     = (cnt_r == CountW'(FrameHalfBits - 1));

  always_comb begin
    collecting_nxt = collecting_r;
    cnt_nxt        = cnt_r;
    shift_nxt      = shift_r;
    frame_nxt      = frame_r;
    // decoder takes the held frame
    if (frame_r.vld && dec_ready) begin
      frame_nxt.vld = 1'b0;
    end
    if (xfer) begin
      if (!collecting_r) begin
        // a pulse while idle is half-bit 0
        if (in_pulse_seen) begin
          collecting_nxt = 1'b1;
          cnt_nxt        = CountW'(1);
          shift_nxt      = ShiftW'(1);
        end
      end else if (last) begin
        collecting_nxt = 1'b0;
        cnt_nxt        = '0;
        frame_nxt.vld  = 1'b1;
        frame_nxt.bits = {shift_r, in_pulse_seen};
      end else begin
        cnt_nxt   = cnt_r + CountW'(1);
        shift_nxt = {shift_r[ShiftW-2:0], in_pulse_seen};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      cnt_r        <= '0;
      shift_r      <= '0;
      frame_r.vld  <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
      cnt_r        <= cnt_nxt;
      shift_r      <= shift_nxt;
      frame_r.vld  <= frame_nxt.vld;
    end
    frame_r.bits <= frame_nxt.bits;
  end

  assign frame = frame_r;

endmodule

/* rtl/irpfd_decode.sv */
// ----------------------------------------------------------------------------
// irpfd_decode
// Frame checker and byte classifier: validates start, data, check and stop
// half-bits, tracks drawing mode and blocks, and registers the result.
// ----------------------------------------------------------------------------
module irpfd_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  irpfd_pkg::frame_t frame,
  output logic              dec_ready,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_frame_status,
  output logic [7:0]        out_data_byte,
  output logic              out_stop_error,
  output logic              out_check_invalid,
  output logic              out_check_mismatch,
  output logic [2:0]        out_byte_kind,
  output logic [7:0]        out_column_index,
  output logic              out_block_done,
  output logic              out_drawing_ended,
  output logic              out_drawing_active
);
  import irpfd_pkg::*;

  // Configuration and drawing state
  logic [3:0] bpi_r;
  logic       draw_r, draw_nxt;
  logic [7:0] col_exp_r, col_exp_nxt;
  logic [7:0] col_cnt_r, col_cnt_nxt;
  logic [3:0] blk_cnt_r, blk_cnt_nxt;

  // Result register
  logic       out_vld_r;
  status_t    status_r, status_nxt;
  logic [7:0] data_r, data_nxt;
  logic       stop_err_r, stop_err_nxt;
  logic       chk_bad_r, chk_bad_nxt;
  logic       chk_mis_r, chk_mis_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] col_idx_r, col_idx_nxt;
  logic       blk_done_r, blk_done_nxt;
  logic       ended_r, ended_nxt;
  logic       active_r, active_nxt;

  // Field extraction
  logic [7:0] data;
  logic       data_bad;
  logic [3:0] recv_chk;
  logic       chk_bad;
  logic [3:0] calc_chk;
  logic       start_ok;
  logic       stop_err;
  logic       load;

  assign dec_ready = !out_vld_r || !out_stall;
  assign load      = frame.vld && dec_ready;

  // Pairs decode as 10 -> 1, 01 -> 0, anything else invalid
  always_comb begin
    data_bad = 1'b0;
    chk_bad  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      data[7-k] = frame.bits[18-2*k];
      if (frame.bits[18-2*k] == frame.bits[17-2*k]) data_bad = 1'b1;
    end
    for (int k = 0; k < 4; k++) begin
      recv_chk[3-k] = frame.bits[26-2*k];
      if (frame.bits[26-2*k] == frame.bits[25-2*k]) chk_bad = 1'b1;
    end
    for (int k = 0; k < 4; k++) begin
      calc_chk[3-k] = ^(CheckMask[k] & data);
    end
  end

  assign start_ok = &frame.bits[29:27];
  assign stop_err = |frame.bits[2:0];

  // Classification and state update
  always_comb begin
    logic [7:0] cc_inc;
    logic [3:0] bc_new;
    draw_nxt     = draw_r;
    col_exp_nxt  = col_exp_r;
    col_cnt_nxt  = col_cnt_r;
    blk_cnt_nxt  = blk_cnt_r;
    status_nxt   = STAT_OK;
    data_nxt     = '0;
    stop_err_nxt = 1'b0;
    chk_bad_nxt  = 1'b0;
    chk_mis_nxt  = 1'b0;
    kind_nxt     = KIND_NONE;
    col_idx_nxt  = '0;
    blk_done_nxt = 1'b0;
    ended_nxt    = 1'b0;
    cc_inc       = col_cnt_r + 8'd1;
    bc_new       = blk_cnt_r;
    priority if (!start_ok) begin
      status_nxt = STAT_BAD_START;
    end else if (data_bad) begin
      status_nxt = STAT_BAD_PAIR;
    end else begin
      data_nxt     = data;
      stop_err_nxt = stop_err;
      chk_bad_nxt  = chk_bad;
      chk_mis_nxt  = !chk_bad && (recv_chk != calc_chk);
      priority if (data == ByteEot) begin
        kind_nxt = KIND_EOT;
      end else if (data == ByteDrawOn) begin
        kind_nxt = KIND_DRAW_ON;
        draw_nxt = 1'b1;
      end else if (draw_r) begin
        if (col_exp_r == '0) begin
          kind_nxt    = KIND_COL_CNT;
          col_exp_nxt = data;
        end else begin
          kind_nxt    = KIND_COLUMN;
          col_idx_nxt = col_cnt_r;
          col_cnt_nxt = cc_inc;
          // block complete: clear column counters, count the block
          if (cc_inc >= col_exp_r) begin
            blk_done_nxt = 1'b1;
            col_cnt_nxt  = '0;
            col_exp_nxt  = '0;
            bc_new       = blk_cnt_r + 4'd1;
          end
          blk_cnt_nxt = bc_new;
          // image complete: leave drawing mode
          if (bc_new >= bpi_r) begin
            blk_cnt_nxt = '0;
            draw_nxt    = 1'b0;
            ended_nxt   = 1'b1;
          end
        end
      end else begin
        kind_nxt = KIND_TEXT;
      end
    end
    active_nxt = draw_nxt;
  end

  // State, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r     <= BlocksPerImageRst;
      draw_r    <= 1'b0;
      col_exp_r <= '0;
      col_cnt_r <= '0;
      blk_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bpi_r <= cfg_wr_data;
      end
      if (load) begin
        draw_r    <= draw_nxt;
        col_exp_r <= col_exp_nxt;
        col_cnt_r <= col_cnt_nxt;
        blk_cnt_r <= blk_cnt_nxt;
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    if (load) begin
      status_r   <= status_nxt;
      data_r     <= data_nxt;
      stop_err_r <= stop_err_nxt;
      chk_bad_r  <= chk_bad_nxt;
      chk_mis_r  <= chk_mis_nxt;
      kind_r     <= kind_nxt;
      col_idx_r  <= col_idx_nxt;
      blk_done_r <= blk_done_nxt;
      ended_r    <= ended_nxt;
      active_r   <= active_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_frame_status   = status_r;
  assign out_data_byte      = data_r;
  assign out_stop_error     = stop_err_r;
  assign out_check_invalid  = chk_bad_r;
  assign out_check_mismatch = chk_mis_r;
  assign out_byte_kind      = kind_r;
  assign out_column_index   = col_idx_r;
  assign out_block_done     = blk_done_r;
  assign out_drawing_ended  = ended_r;
  assign out_drawing_active = active_r;

endmodule

/* rtl/infrared_printer_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// infrared_printer_frame_decoder_unit
// Top level of the infrared printer frame receiver: half-bit collector
// followed by the frame checker and byte classifier.
// ----------------------------------------------------------------------------
// One half-bit slot is taken per transfer, every cycle when neither side
// stalls. A pulse while idle opens a frame; the thirtieth slot completes it,
// the frame is held in the collector's frame register and is then decoded
// into the result register. Slots with no frame open produce no result. The
// input stalls only while a completed frame is held and the result register
// is still full and stalled. cfg_wr_data sets the blocks per image (reset 4);
// write it only while no frame is in flight.
module infrared_printer_frame_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_pulse_seen,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_frame_status,
  output logic [7:0] out_data_byte,
  output logic       out_stop_error,
  output logic       out_check_invalid,
  output logic       out_check_mismatch,
  output logic [2:0] out_byte_kind,
  output logic [7:0] out_column_index,
  output logic       out_block_done,
  output logic       out_drawing_ended,
  output logic       out_drawing_active
);
  import irpfd_pkg::*;

  frame_t frame;
  logic   dec_ready;

  // Half-bit collection
  irpfd_collect u_collect (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pulse_seen(in_pulse_seen),
    .dec_ready    (dec_ready),
    .frame        (frame)
  );

  // Frame check, classification and result register
  irpfd_decode u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame             (frame),
    .dec_ready         (dec_ready),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_status  (out_frame_status),
    .out_data_byte     (out_data_byte),
    .out_stop_error    (out_stop_error),
    .out_check_invalid (out_check_invalid),
    .out_check_mismatch(out_check_mismatch),
    .out_byte_kind     (out_byte_kind),
    .out_column_index  (out_column_index),
    .out_block_done    (out_block_done),
    .out_drawing_ended (out_drawing_ended),
    .out_drawing_active(out_drawing_active)
  );

endmodule

/* tb/infrared_printer_frame_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// infrared_printer_frame_decoder_unit_tb
// Self-checking bench for the infrared printer frame decoder. Half-bit slots
// are sent as 30-slot frames, some well formed and some broken, with idle
// slots and noise between them. A frame model in the bench predicts each
// decoded result, and every result transfer is checked field by field. The
// directed frames come first. Random phases follow, each with its own
// blocks-per-image setting, and in most of them both sides idle and stall at random.
// ----------------------------------------------------------------------------
module infrared_printer_frame_decoder_unit_tb;
  import irpfd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LATENCY_PAD = 6;
  localparam int NO_PAIR     = -1;
  localparam int SLOTS       = 30;

  // Parity masks, check bit 3 down to check bit 0
  localparam logic [7:0] MASK_C3 = 8'h78;
  localparam logic [7:0] MASK_C2 = 8'hE6;
  localparam logic [7:0] MASK_C1 = 8'hD5;
  localparam logic [7:0] MASK_C0 = 8'h8B;

  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       stop_err;
    logic       chk_invalid;
    logic       chk_mismatch;
    kind_t      kind;
    logic [7:0] col_idx;
    logic       blk_done;
    logic       draw_ended;
    logic       draw_active;
  } frame_result_t;

  typedef struct {
    logic [29:0]   frame;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic       clk                = 1'b0;
  logic       rst_n              = 1'b0;
  logic       in_valid           = 1'b0;
  logic       in_pulse_seen      = 1'b0;
  logic       cfg_wr_en          = 1'b0;
  logic [3:0] cfg_wr_data        = 4'd0;
  logic       out_stall          = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_frame_status;
  logic [7:0] out_data_byte;
  logic       out_stop_error;
  logic       out_check_invalid;
  logic       out_check_mismatch;
  logic [2:0] out_byte_kind;
  logic [7:0] out_column_index;
  logic       out_block_done;
  logic       out_drawing_ended;
  logic       out_drawing_active;

  // Frame model state
  logic        frame_open   = 1'b0;
  int          slot_count   = 0;
  logic [29:0] slot_shift   = '0;
  logic        draw_mode    = 1'b0;
  logic [7:0]  cols_due     = 8'd0;
  logic [7:0]  cols_seen    = 8'd0;
  logic [3:0]  blocks_seen  = 4'd0;
  logic [3:0]  blocks_limit = BlocksPerImageRst;

  frame_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  frame_result_t due_result;
  int            mismatches  = 0;
  int            slots_sent  = 0;
  int            frames_due  = 0;
  int            cycle_count = 0;
  logic          tx_quiet    = 1'b0;
  logic          rx_quiet    = 1'b0;

  infrared_printer_frame_decoder_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pulse_seen      (in_pulse_seen),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_status   (out_frame_status),
    .out_data_byte      (out_data_byte),
    .out_stop_error     (out_stop_error),
    .out_check_invalid  (out_check_invalid),
    .out_check_mismatch (out_check_mismatch),
    .out_byte_kind      (out_byte_kind),
    .out_column_index   (out_column_index),
    .out_block_done     (out_block_done),
    .out_drawing_ended  (out_drawing_ended),
    .out_drawing_active (out_drawing_active)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("infrared_printer_frame_decoder_unit test failed");
      $finish;
    end
  end

  function automatic logic [3:0] check_bits(logic [7:0] d);
    return {^(d & MASK_C3), ^(d & MASK_C2), ^(d & MASK_C1), ^(d & MASK_C0)};
  endfunction

  // Half of the waits are zero, all of them on a quiet side; the rest are random
  function automatic int draw_wait(logic quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  function automatic frame_result_t mk_result(status_t s, logic [7:0] d, logic se,
                                              logic ci, logic cm, kind_t k,
                                              logic [7:0] idx, logic bd, logic de,
                                              logic da);
    frame_result_t r;
    r = '{s, d, se, ci, cm, k, idx, bd, de, da};
    return r;
  endfunction

  // Build 30 slots, half-bit 0 at bit 29; a forced bad pair is 11 on even
  // positions and 00 on odd ones
  function automatic logic [29:0] make_frame(logic [2:0] start, logic [7:0] d,
                                             logic [3:0] chk_xor, int chk_bad,
                                             int data_bad, logic [2:0] stop);
    logic [29:0] f;
    logic [3:0]  chk;
    logic [1:0]  pr;
    int          i;
    chk = check_bits(d) ^ chk_xor;
    f = '0;
    f[29:27] = start;
    for (i = 0; i < 4; i++) begin
      pr = chk[3-i] ? 2'b10 : 2'b01;
      if (i == chk_bad) pr = i[0] ? 2'b00 : 2'b11;
      f[26-2*i -: 2] = pr;
    end
    for (i = 0; i < 8; i++) begin
      pr = d[7-i] ? 2'b10 : 2'b01;
      if (i == data_bad) pr = i[0] ? 2'b00 : 2'b11;
      f[18-2*i -: 2] = pr;
    end
    f[2:0] = stop;
    return f;
  endfunction

  // Check a complete frame and update the drawing state
  function automatic frame_result_t classify_frame(logic [29:0] sh);
    frame_result_t r;
    logic [7:0]    d;
    logic [3:0]    rc;
    int            i;
    r = '0;
    r.status = STAT_OK;
    r.kind = KIND_NONE;
    r.draw_active = draw_mode;
    d = '0;
    rc = '0;
    if (sh[29:27] != 3'b111) begin
      r.status = STAT_BAD_START;
      return r;
    end
    for (i = 0; i < 8; i++) begin
      if (sh[18-2*i] == sh[17-2*i]) begin
        r.status = STAT_BAD_PAIR;
        return r;
      end
      d = {d[6:0], sh[18-2*i]};
    end
    // first bad check pair stops check decoding
    for (i = 0; i < 4; i++) begin
      if (!r.chk_invalid) begin
        if (sh[26-2*i] == sh[25-2*i]) r.chk_invalid = 1'b1;
        else rc = {rc[2:0], sh[26-2*i]};
      end
    end
    r.data = d;
    r.stop_err = |sh[2:0];
    r.chk_mismatch = !r.chk_invalid && (rc != check_bits(d));
    if (d == ByteEot) begin
      r.kind = KIND_EOT;
    end else if (d == ByteDrawOn) begin
      r.kind = KIND_DRAW_ON;
      draw_mode = 1'b1;
    end else if (draw_mode) begin
      if (cols_due == 8'd0) begin
        cols_due = d;
        r.kind = KIND_COL_CNT;
      end else begin
        r.kind = KIND_COLUMN;
        r.col_idx = cols_seen;
        cols_seen = cols_seen + 8'd1;
        if (cols_seen >= cols_due) begin
          r.blk_done = 1'b1;
          cols_seen = 8'd0;
          cols_due = 8'd0;
          blocks_seen = blocks_seen + 4'd1;
        end
        if (blocks_seen >= blocks_limit) begin
          blocks_seen = 4'd0;
          draw_mode = 1'b0;
          r.draw_ended = 1'b1;
        end
      end
    end else begin
      r.kind = KIND_TEXT;
    end
    r.draw_active = draw_mode;
    return r;
  endfunction

  // Advance the collector by one accepted slot
  task automatic take_slot(input logic pulse, output logic produced,
                           output frame_result_t r);
    produced = 1'b0;
    r = '0;
    if (frame_open || pulse) begin
      if (!frame_open) begin
        frame_open = 1'b1;
        slot_count = 0;
        slot_shift = '0;
      end
      slot_shift = {slot_shift[28:0], pulse};
      slot_count = slot_count + 1;
      if (slot_count == SLOTS) begin
        frame_open = 1'b0;
        slot_count = 0;
        r = classify_frame(slot_shift);
        produced = 1'b1;
      end
    end
  endtask

  // One slot transfer; a typed row supplies its own expected result
  task automatic send_slot(input logic pulse, input logic typed,
                           input frame_result_t want);
    int            gap;
    logic          ok;
    logic          produced;
    frame_result_t r;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pulse_seen <= pulse;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    slots_sent = slots_sent + 1;
    take_slot(pulse, produced, r);
    if (produced) begin
      pending_results.push_back(typed ? want : r);
      frames_due = frames_due + 1;
    end
  endtask

  task automatic send_frame(input logic [29:0] f, input logic typed,
                            input frame_result_t want);
    int h;
    for (h = 0; h < SLOTS; h++) send_slot(f[29-h], typed, want);
  endtask

  // Close any open frame, then wait until every result has been taken
  task automatic drain_pipeline();
    while (frame_open) send_slot(1'b0, 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // Byte choice leans on drawing sequences with short blocks
  task automatic send_random_frame();
    logic [7:0] d;
    logic [2:0] start;
    logic [2:0] stop;
    logic [3:0] cx;
    int         cb;
    int         db;
    int         x;
    x = $urandom_range(0, 99);
    if (x < 15) d = ByteDrawOn;
    else if (x < 20) d = ByteEot;
    else if (draw_mode && cols_due == 8'd0)
      d = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 3));
    else d = 8'($urandom_range(0, 255));
    start = 3'b111;
    cx = 4'd0;
    cb = NO_PAIR;
    db = NO_PAIR;
    stop = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
    x = $urandom_range(0, 99);
    if (x < 7) start = {1'b1, 2'($urandom_range(0, 2))};
    else if (x < 14) db = $urandom_range(0, 7);
    else if (x < 21) cb = $urandom_range(0, 3);
    else if (x < 31) cx = 4'($urandom_range(1, 15));
    send_frame(make_frame(start, d, cx, cb, db, stop), 1'b0, '0);
  endtask

  task automatic run_random_phase();
    int slots_at;
    int frames_at;
    int k;
    slots_at = slots_sent;
    frames_at = frames_due;
    while (slots_sent - slots_at < 96 || frames_due - frames_at < 3) begin
      send_random_frame();
      k = $urandom_range(0, 99);
      if (k < 3) begin
        // noise: random slots that may leave a frame open
        repeat ($urandom_range(1, 40)) send_slot(1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (k < 6) begin
        drain_pipeline();
      end else if (k < 50) begin
        repeat ($urandom_range(1, 3)) send_slot(1'b0, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // Result side: random stall before each transfer
  initial begin
    int   n;
    logic took;
    forever begin
      n = draw_wait(rx_quiet);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  // Result check, sampled mid-cycle ahead of the transfer edge
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0d", $time,
                 out_data_byte);
        mismatches = mismatches + 1;
      end else begin
        due_result = pending_results.pop_front();
        check_field("frame_status", due_result.status, out_frame_status);
        check_field("data_byte", due_result.data, out_data_byte);
        check_field("stop_error", due_result.stop_err, out_stop_error);
        check_field("check_invalid", due_result.chk_invalid, out_check_invalid);
        check_field("check_mismatch", due_result.chk_mismatch, out_check_mismatch);
        check_field("byte_kind", due_result.kind, out_byte_kind);
        check_field("column_index", due_result.col_idx, out_column_index);
        check_field("block_done", due_result.blk_done, out_block_done);
        check_field("drawing_ended", due_result.draw_ended, out_drawing_ended);
        check_field("drawing_active", due_result.draw_active, out_drawing_active);
      end
    end
  end

  // Main sequence
  initial begin
    logic [3:0] phase_limits [6];
    int         p;
    phase_limits = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd9, 4'd4};

    // Directed frames from reset, blocks per image still 4
    directed_rows.push_back('{make_frame(3'b111, 8'h00, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'h00, 0, 0, 0, KIND_TEXT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'hFF, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'hFF, 0, 0, 0, KIND_TEXT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b101, 8'h3C, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_BAD_START, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b110, 8'h3C, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_BAD_START, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'h81, 4'd0, NO_PAIR, 7, 3'b000),
      1'b1, mk_result(STAT_BAD_PAIR, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'h81, 4'd0, NO_PAIR, 0, 3'b111),
      1'b1, mk_result(STAT_BAD_PAIR, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'h55, 4'd0, 2, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'h55, 0, 1, 0, KIND_TEXT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'hA3, 4'd1, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'hA3, 0, 0, 1, KIND_TEXT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'h12, 4'd0, NO_PAIR, NO_PAIR, 3'b111),
      1'b1, mk_result(STAT_OK, 8'h12, 1, 0, 0, KIND_TEXT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, 8'h6B, 4'd8, 1, NO_PAIR, 3'b001),
      1'b0, '0});
    directed_rows.push_back('{make_frame(3'b111, ByteEot, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, ByteEot, 0, 0, 0, KIND_EOT, 0, 0, 0, 0)});
    directed_rows.push_back('{make_frame(3'b111, ByteDrawOn, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, ByteDrawOn, 0, 0, 0, KIND_DRAW_ON, 0, 0, 0, 1)});
    // zero column count keeps the next byte a count
    directed_rows.push_back('{make_frame(3'b111, 8'h00, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'h00, 0, 0, 0, KIND_COL_CNT, 0, 0, 0, 1)});
    directed_rows.push_back('{make_frame(3'b111, 8'h02, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'h02, 0, 0, 0, KIND_COL_CNT, 0, 0, 0, 1)});
    directed_rows.push_back('{make_frame(3'b111, 8'hFF, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'hFF, 0, 0, 0, KIND_COLUMN, 0, 0, 0, 1)});
    // commands inside a block are never columns
    directed_rows.push_back('{make_frame(3'b111, ByteDrawOn, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, ByteDrawOn, 0, 0, 0, KIND_DRAW_ON, 0, 0, 0, 1)});
    directed_rows.push_back('{make_frame(3'b111, ByteEot, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, ByteEot, 0, 0, 0, KIND_EOT, 0, 0, 0, 1)});
    directed_rows.push_back('{make_frame(3'b111, 8'h00, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_OK, 8'h00, 0, 0, 0, KIND_COLUMN, 1, 1, 0, 1)});
    directed_rows.push_back('{make_frame(3'b100, 8'h00, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b1, mk_result(STAT_BAD_START, 0, 0, 0, 0, KIND_NONE, 0, 0, 0, 1)});
    directed_rows.push_back('{make_frame(3'b111, 8'h01, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b0, '0});
    directed_rows.push_back('{make_frame(3'b111, 8'h9E, 4'd0, NO_PAIR, NO_PAIR, 3'b000),
      1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);

    // Random phase at the reset setting, then one phase per setting
    run_random_phase();
    for (p = 0; p < 6; p++) begin
      drain_pipeline();
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= phase_limits[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      blocks_limit = phase_limits[p];
      tx_quiet = (p == 1 || p == 4);
      rx_quiet = (p == 2 || p == 4);
      run_random_phase();
    end
    drain_pipeline();

    if (mismatches == 0) begin
      $display("infrared_printer_frame_decoder_unit test passed");
    end else begin
      $display("infrared_printer_frame_decoder_unit test failed");
    end
    $finish;
  end

endmodule
